// File: rtl/core/gjd_pkg.sv
// ----------------------------------------------------------------------------
// gjd_pkg
// Shared types, constants and the byte map for the Gujarati byte decoder.
// ----------------------------------------------------------------------------
package gjd_pkg;

   // Byte codes that start or close a two-byte sequence.
   localparam logic [7:0] NUKTA_BYTE  = 8'hE9;
   localparam logic [7:0] VIRAMA_BYTE = 8'hE8;
   localparam logic [7:0] LEAD_A1     = 8'hA1;
   localparam logic [7:0] LEAD_AA     = 8'hAA;
   localparam logic [7:0] LEAD_DF     = 8'hDF;

   // Code points produced by the two-byte sequences.
   localparam logic [13:0] CP_OM     = 14'h0AD0;
   localparam logic [13:0] CP_RR     = 14'h0AE0;
   localparam logic [13:0] CP_RRV    = 14'h0AC4;
   localparam logic [13:0] CP_VIRAMA = 14'h0ACD;
   localparam logic [13:0] CP_ZWNJ   = 14'h200C;
   localparam logic [13:0] CP_ZWJ    = 14'h200D;

   // Which lead byte is held back.
   typedef enum logic [1:0] {
      KIND_A1 = 2'd0,
      KIND_AA = 2'd1,
      KIND_DF = 2'd2,
      KIND_E8 = 2'd3
   } gjd_kind_type;

   // One queue entry: the results caused by one input byte.
   typedef struct packed {
      logic        two_results;
      logic [13:0] cp_first;
      logic [13:0] cp_second;
   } gjd_entry_type;

   // Code points for bytes 0x80 to 0xFF; zero marks an unmapped byte.
   localparam logic [13:0] HIGH_ROM [128] = '{
      14'h00D7, 14'h2212, 14'h2013, 14'h2014, 14'h2018, 14'h2019, 14'h2026, 14'h2022,
      14'h00A9, 14'h00AE, 14'h2122, 14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0000,
      14'h0965, 14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0000,
      14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0000,
      14'h0000, 14'h0A81, 14'h0A82, 14'h0A83, 14'h0A85, 14'h0A86, 14'h0A87, 14'h0A88,
      14'h0A89, 14'h0A8A, 14'h0A8B, 14'h0000, 14'h0A8F, 14'h0A90, 14'h0A8D, 14'h0000,
      14'h0A93, 14'h0A94, 14'h0A91, 14'h0A95, 14'h0A96, 14'h0A97, 14'h0A98, 14'h0A99,
      14'h0A9A, 14'h0A9B, 14'h0A9C, 14'h0A9D, 14'h0A9E, 14'h0A9F, 14'h0AA0, 14'h0AA1,
      14'h0AA2, 14'h0AA3, 14'h0AA4, 14'h0AA5, 14'h0AA6, 14'h0AA7, 14'h0AA8, 14'h0000,
      14'h0AAA, 14'h0AAB, 14'h0AAC, 14'h0AAD, 14'h0AAE, 14'h0AAF, 14'h0000, 14'h0AB0,
      14'h0000, 14'h0AB2, 14'h0AB3, 14'h0000, 14'h0AB5, 14'h0AB6, 14'h0AB7, 14'h0AB8,
      14'h0AB9, 14'h200E, 14'h0ABE, 14'h0ABF, 14'h0AC0, 14'h0AC1, 14'h0AC2, 14'h0AC3,
      14'h0000, 14'h0AC7, 14'h0AC8, 14'h0AC5, 14'h0000, 14'h0ACB, 14'h0ACC, 14'h0AC9,
      14'h0ACD, 14'h0ABC, 14'h0964, 14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0000,
      14'h0000, 14'h0AE6, 14'h0AE7, 14'h0AE8, 14'h0AE9, 14'h0AEA, 14'h0AEB, 14'h0AEC,
      14'h0AED, 14'h0AEE, 14'h0AEF, 14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0000
   };

   // Maps one byte to its code point: ASCII passes, the upper half uses the ROM.
   function automatic logic [13:0] map_byte(input logic [7:0] b);
      logic [13:0] cp;
      if (b[7] == 1'b0) begin
         cp = {6'd0, b};
      end else begin
         cp = HIGH_ROM[b[6:0]];
      end
      return cp;
   endfunction

   // Byte value of a held lead kind.
   function automatic logic [7:0] kind_byte(input gjd_kind_type k);
      logic [7:0] b;
      case (k)
         KIND_A1: b = LEAD_A1;
         KIND_AA: b = LEAD_AA;
         KIND_DF: b = LEAD_DF;
         KIND_E8: b = VIRAMA_BYTE;
         default: b = LEAD_A1;
      endcase
      return b;
   endfunction

   // Code point of a lead byte joined with a nukta.
   function automatic logic [13:0] kind_pair(input gjd_kind_type k);
      logic [13:0] cp;
      case (k)
         KIND_A1: cp = CP_OM;
         KIND_AA: cp = CP_RR;
         KIND_DF: cp = CP_RRV;
         default: cp = CP_OM;
      endcase
      return cp;
   endfunction

endpackage

// File: rtl/core/gjd_front.sv
// ----------------------------------------------------------------------------
// gjd_front
// Accepts input bytes, tracks the held lead byte and turns each byte into
// a queue entry of one or two code points (or none while a byte is held).
// ----------------------------------------------------------------------------
module gjd_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_in_byte,
   input  logic                   req_end_of_stream,
   input  logic                   queue_full,
   output logic                   push_valid,
   output gjd_pkg::gjd_entry_type push_entry,
   output logic                   held_valid
);

   logic                 held_valid_ff;
   logic                 held_valid_in;
   gjd_pkg::gjd_kind_type held_kind_ff;
   gjd_pkg::gjd_kind_type held_kind_in;
   logic                 accept;
   logic                 is_lead;
   gjd_pkg::gjd_kind_type new_kind;
   logic [13:0]          flush_cp;
   logic [13:0]          byte_cp;
   logic [1:0]           result_count;
   logic [13:0]          cp_first;
   logic [13:0]          cp_second;

   assign req_stall  = queue_full;
   assign accept     = req_valid && !req_stall;
   assign held_valid = held_valid_ff;

   // Classify the incoming byte as a possible lead byte.
   always_comb begin
      is_lead  = 1'b1;
      new_kind = gjd_pkg::KIND_A1;
      case (req_in_byte)
         gjd_pkg::LEAD_A1:     new_kind = gjd_pkg::KIND_A1;
         gjd_pkg::LEAD_AA:     new_kind = gjd_pkg::KIND_AA;
         gjd_pkg::LEAD_DF:     new_kind = gjd_pkg::KIND_DF;
         gjd_pkg::VIRAMA_BYTE: new_kind = gjd_pkg::KIND_E8;
         default:              is_lead  = 1'b0;
      endcase
   end

   assign flush_cp = gjd_pkg::map_byte(gjd_pkg::kind_byte(held_kind_ff));
   assign byte_cp  = gjd_pkg::map_byte(req_in_byte);

   // Decide the results of this beat and the next held state.
   always_comb begin
      result_count  = 2'd0;
      cp_first      = byte_cp;
      cp_second     = byte_cp;
      held_valid_in = 1'b0;
      held_kind_in  = held_kind_ff;
      if (held_valid_ff) begin
         if (held_kind_ff == gjd_pkg::KIND_E8 &&
             (req_in_byte == gjd_pkg::VIRAMA_BYTE || req_in_byte == gjd_pkg::NUKTA_BYTE)) begin
            // Virama pair: virama then a zero-width joiner or non-joiner.
            result_count = 2'd2;
            cp_first     = gjd_pkg::CP_VIRAMA;
            cp_second    = (req_in_byte == gjd_pkg::VIRAMA_BYTE) ?
                           gjd_pkg::CP_ZWNJ : gjd_pkg::CP_ZWJ;
         end else if (held_kind_ff != gjd_pkg::KIND_E8 &&
                      req_in_byte == gjd_pkg::NUKTA_BYTE) begin
            // Lead byte with nukta folds into one code point.
            result_count = 2'd1;
            cp_first     = gjd_pkg::kind_pair(held_kind_ff);
         end else if (is_lead && !req_end_of_stream) begin
            // Flush the old lead byte and hold the new one.
            result_count  = 2'd1;
            cp_first      = flush_cp;
            held_valid_in = 1'b1;
            held_kind_in  = new_kind;
         end else begin
            result_count = 2'd2;
            cp_first     = flush_cp;
            cp_second    = byte_cp;
         end
      end else if (is_lead && !req_end_of_stream) begin
         held_valid_in = 1'b1;
         held_kind_in  = new_kind;
      end else begin
         result_count = 2'd1;
      end
   end

   assign push_valid             = accept && (result_count != 2'd0);
   assign push_entry.two_results = (result_count == 2'd2);
   assign push_entry.cp_first    = cp_first;
   assign push_entry.cp_second   = cp_second;

   // Held lead byte state, updated on every accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_kind_ff  <= gjd_pkg::KIND_A1;
      end else if (accept) begin
         held_valid_ff <= held_valid_in;
         held_kind_ff  <= held_kind_in;
      end
   end

endmodule

// File: rtl/core/gjd_queue.sv
// ----------------------------------------------------------------------------
// gjd_queue
// Small first-in first-out buffer of result entries between the front and
// the back end.
// ----------------------------------------------------------------------------
module gjd_queue #(
   parameter int DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  gjd_pkg::gjd_entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output gjd_pkg::gjd_entry_type head_entry
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   gjd_pkg::gjd_entry_type entries_ff [DEPTH];
   logic [AW-1:0]          wr_ptr_ff;
   logic [AW-1:0]          wr_ptr_in;
   logic [AW-1:0]          rd_ptr_ff;
   logic [AW-1:0]          rd_ptr_in;
   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/core/gjd_back.sv
// ----------------------------------------------------------------------------
// gjd_back
// Drains queue entries onto the result channel, one code point per beat,
// and marks the final code point of each entry.
// ----------------------------------------------------------------------------
module gjd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  gjd_pkg::gjd_entry_type head_entry,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [13:0]            rsp_code_point,
   output logic                   rsp_last_in_run
);

   logic second_ff;
   logic second_in;
   logic beat_done;

   assign rsp_valid       = head_valid;
   assign rsp_code_point  = second_ff ? head_entry.cp_second : head_entry.cp_first;
   assign rsp_last_in_run = second_ff || !head_entry.two_results;
   assign beat_done       = rsp_valid && !rsp_stall;
   assign pop             = beat_done && rsp_last_in_run;

   // Step to the second code point of a two-result entry.
   always_comb begin
      second_in = second_ff;
      if (beat_done) begin
         second_in = !rsp_last_in_run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= 1'b0;
      end else begin
         second_ff <= second_in;
      end
   end

endmodule

// File: rtl/core/gujarati_byte_to_unicode_decoder.sv
// ----------------------------------------------------------------------------
// gujarati_byte_to_unicode_decoder
// Decodes a stream of Gujarati-charset bytes into Unicode code points.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Beat contents
//   req      in         in_byte, end_of_stream
//   rsp      out        code_point, last_in_run
//
// One input beat is taken per cycle while the result queue has room.
// Each byte makes zero, one or two result beats; the result channel moves one
// beat per cycle unless stalled, so two-result bytes set its sustained rate.
// With the queue empty, the first result of a byte shows on the result
// channel the cycle after the byte is accepted; a held lead byte waits for
// the next byte.
// Reset is synchronous and clears the held lead byte and the queue.
// A stalled result channel fills the QUEUE_DEPTH entry queue, then stalls req.
//
module gujarati_byte_to_unicode_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [13:0] rsp_code_point,
   output logic        rsp_last_in_run
);

   logic                   queue_full;
   logic                   push_valid;
   gjd_pkg::gjd_entry_type push_entry;
   logic                   pop;
   logic                   head_valid;
   gjd_pkg::gjd_entry_type head_entry;
   logic                   held_valid;

   gjd_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_stream (req_end_of_stream),
      .queue_full        (queue_full),
      .push_valid        (push_valid),
      .push_entry        (push_entry),
      .held_valid        (held_valid)
   );

   gjd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   gjd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_entry      (head_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_point  (rsp_code_point),
      .rsp_last_in_run (rsp_last_in_run)
   );

   // An end-of-stream beat never leaves a lead byte held.
   a_eos_flushes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_end_of_stream) |=> !held_valid)
      else $error("lead byte still held after end of stream");

   // The first beat of a pair is always followed by its second beat.
   a_pair_complete: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_in_run) |=> rsp_valid)
      else $error("second result of a pair went missing");

   // Nothing is offered on the result channel right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Gujarati byte to Unicode decoder. A short
// table of directed bytes covers the range ends, every lead byte and every
// two-byte sequence. Weighted random bytes follow, rich in lead and partner
// bytes. Both channels idle at random. Every result beat is checked against
// the typed rows' own expected code points or an in-bench decoder model.
// ----------------------------------------------------------------------------
module testbench;

   // One expected result beat.
   typedef struct packed {
      logic [13:0] cp;
      logic        last;
   } cp_beat_type;

   // One directed stimulus row; typed rows carry their own expected code points.
   typedef struct packed {
      logic [7:0]  in_b;
      logic        eos;
      logic        typed;
      logic [1:0]  n_typed;
      logic [13:0] cp_a;
      logic [13:0] cp_b;
   } dir_row_type;

   localparam int DIR_ROWS    = 25;
   localparam int RAND_BEATS  = 1900;
   localparam int PAUSE_AT    = 950;
   localparam int DRAIN_TAIL  = 20;

   // Code points of bytes 0x80 to 0xFF; zero marks an unmapped byte.
   localparam logic [13:0] UPPER_HALF_MAP [128] = '{
      14'h00D7, 14'h2212, 14'h2013, 14'h2014, 14'h2018, 14'h2019, 14'h2026, 14'h2022,
      14'h00A9, 14'h00AE, 14'h2122, 14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0000,
      14'h0965, 14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0000,
      14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0000,
      14'h0000, 14'h0A81, 14'h0A82, 14'h0A83, 14'h0A85, 14'h0A86, 14'h0A87, 14'h0A88,
      14'h0A89, 14'h0A8A, 14'h0A8B, 14'h0000, 14'h0A8F, 14'h0A90, 14'h0A8D, 14'h0000,
      14'h0A93, 14'h0A94, 14'h0A91, 14'h0A95, 14'h0A96, 14'h0A97, 14'h0A98, 14'h0A99,
      14'h0A9A, 14'h0A9B, 14'h0A9C, 14'h0A9D, 14'h0A9E, 14'h0A9F, 14'h0AA0, 14'h0AA1,
      14'h0AA2, 14'h0AA3, 14'h0AA4, 14'h0AA5, 14'h0AA6, 14'h0AA7, 14'h0AA8, 14'h0000,
      14'h0AAA, 14'h0AAB, 14'h0AAC, 14'h0AAD, 14'h0AAE, 14'h0AAF, 14'h0000, 14'h0AB0,
      14'h0000, 14'h0AB2, 14'h0AB3, 14'h0000, 14'h0AB5, 14'h0AB6, 14'h0AB7, 14'h0AB8,
      14'h0AB9, 14'h200E, 14'h0ABE, 14'h0ABF, 14'h0AC0, 14'h0AC1, 14'h0AC2, 14'h0AC3,
      14'h0000, 14'h0AC7, 14'h0AC8, 14'h0AC5, 14'h0000, 14'h0ACB, 14'h0ACC, 14'h0AC9,
      14'h0ACD, 14'h0ABC, 14'h0964, 14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0000,
      14'h0000, 14'h0AE6, 14'h0AE7, 14'h0AE8, 14'h0AE9, 14'h0AEA, 14'h0AEB, 14'h0AEC,
      14'h0AED, 14'h0AEE, 14'h0AEF, 14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0000
   };

   // Directed bytes: range ends, every pair, flushes and final lead bytes.
   dir_row_type dir_rows [DIR_ROWS] = '{
      '{8'h00, 1'b0, 1'b1, 2'd1, 14'h0000, 14'h0000},
      '{8'h7F, 1'b0, 1'b1, 2'd1, 14'h007F, 14'h0000},
      '{8'h80, 1'b0, 1'b1, 2'd1, 14'h00D7, 14'h0000},
      '{8'hFF, 1'b0, 1'b1, 2'd1, 14'h0000, 14'h0000},
      '{gjd_pkg::LEAD_A1, 1'b0, 1'b1, 2'd0, 14'h0000, 14'h0000},
      '{gjd_pkg::NUKTA_BYTE, 1'b0, 1'b1, 2'd1, gjd_pkg::CP_OM, 14'h0000},
      '{gjd_pkg::LEAD_AA, 1'b0, 1'b1, 2'd0, 14'h0000, 14'h0000},
      '{gjd_pkg::NUKTA_BYTE, 1'b0, 1'b1, 2'd1, gjd_pkg::CP_RR, 14'h0000},
      '{gjd_pkg::LEAD_DF, 1'b0, 1'b1, 2'd0, 14'h0000, 14'h0000},
      '{gjd_pkg::NUKTA_BYTE, 1'b0, 1'b1, 2'd1, gjd_pkg::CP_RRV, 14'h0000},
      '{gjd_pkg::VIRAMA_BYTE, 1'b0, 1'b1, 2'd0, 14'h0000, 14'h0000},
      '{gjd_pkg::VIRAMA_BYTE, 1'b0, 1'b1, 2'd2, gjd_pkg::CP_VIRAMA, gjd_pkg::CP_ZWNJ},
      '{gjd_pkg::VIRAMA_BYTE, 1'b0, 1'b1, 2'd0, 14'h0000, 14'h0000},
      '{gjd_pkg::NUKTA_BYTE, 1'b0, 1'b1, 2'd2, gjd_pkg::CP_VIRAMA, gjd_pkg::CP_ZWJ},
      '{gjd_pkg::LEAD_A1, 1'b0, 1'b0, 2'd0, 14'h0000, 14'h0000},
      '{8'h41, 1'b0, 1'b0, 2'd0, 14'h0000, 14'h0000},
      '{gjd_pkg::VIRAMA_BYTE, 1'b0, 1'b0, 2'd0, 14'h0000, 14'h0000},
      '{gjd_pkg::LEAD_A1, 1'b0, 1'b0, 2'd0, 14'h0000, 14'h0000},
      '{gjd_pkg::LEAD_AA, 1'b1, 1'b0, 2'd0, 14'h0000, 14'h0000},
      '{gjd_pkg::LEAD_DF, 1'b1, 1'b0, 2'd0, 14'h0000, 14'h0000},
      '{gjd_pkg::NUKTA_BYTE, 1'b0, 1'b0, 2'd0, 14'h0000, 14'h0000},
      '{gjd_pkg::LEAD_DF, 1'b0, 1'b0, 2'd0, 14'h0000, 14'h0000},
      '{gjd_pkg::VIRAMA_BYTE, 1'b0, 1'b0, 2'd0, 14'h0000, 14'h0000},
      '{8'h00, 1'b1, 1'b0, 2'd0, 14'h0000, 14'h0000},
      '{gjd_pkg::VIRAMA_BYTE, 1'b1, 1'b0, 2'd0, 14'h0000, 14'h0000}
   };

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte       = 8'h00;
   logic        req_end_of_stream = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall         = 1'b0;
   logic [13:0] rsp_code_point;
   logic        rsp_last_in_run;

   // Decoder model state: the lead byte held back, if any.
   logic                  lead_held = 1'b0;
   gjd_pkg::gjd_kind_type held_lead = gjd_pkg::KIND_A1;

   cp_beat_type expected_cps [$];
   int          mismatch_count = 0;

   gujarati_byte_to_unicode_decoder i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_code_point    (rsp_code_point),
      .rsp_last_in_run   (rsp_last_in_run)
   );

   // Free-running clock.
   initial begin
      forever begin
         #6 clock = ~clock;
      end
   end

   // Hard limit on the run length.
   initial begin
      #20000000;
      $display("*** FAILED ***");
      $finish;
   end

   // Single-byte code point: ASCII passes, the upper half goes through the map.
   function automatic logic [13:0] byte_code_point(input logic [7:0] b);
      logic [13:0] cp;
      if (b < 8'h80) begin
         cp = {6'd0, b};
      end else begin
         cp = UPPER_HALF_MAP[b[6:0]];
      end
      return cp;
   endfunction

   // Decodes one accepted byte, updates the held lead and returns the result count.
   function automatic int decode_gujarati(input logic [7:0] b, input logic eos,
                                          output logic [1:0][13:0] cps);
      int                    n;
      logic [7:0]            held_b;
      logic                  is_lead;
      gjd_pkg::gjd_kind_type k;
      n = 0;
      cps = '0;
      if (lead_held) begin
         lead_held = 1'b0;
         // Virama followed by virama or nukta becomes a joiner pair.
         if (held_lead == gjd_pkg::KIND_E8 &&
             (b == gjd_pkg::VIRAMA_BYTE || b == gjd_pkg::NUKTA_BYTE)) begin
            cps[0] = gjd_pkg::CP_VIRAMA;
            cps[1] = (b == gjd_pkg::VIRAMA_BYTE) ? gjd_pkg::CP_ZWNJ : gjd_pkg::CP_ZWJ;
            return 2;
         end
         // Other lead bytes combine with a nukta into one code point.
         if (held_lead != gjd_pkg::KIND_E8 && b == gjd_pkg::NUKTA_BYTE) begin
            case (held_lead)
               gjd_pkg::KIND_A1: cps[0] = gjd_pkg::CP_OM;
               gjd_pkg::KIND_AA: cps[0] = gjd_pkg::CP_RR;
               default:          cps[0] = gjd_pkg::CP_RRV;
            endcase
            return 1;
         end
         // No pair formed: flush the held byte on its own.
         case (held_lead)
            gjd_pkg::KIND_A1: held_b = gjd_pkg::LEAD_A1;
            gjd_pkg::KIND_AA: held_b = gjd_pkg::LEAD_AA;
            gjd_pkg::KIND_DF: held_b = gjd_pkg::LEAD_DF;
            default:          held_b = gjd_pkg::VIRAMA_BYTE;
         endcase
         cps[n] = byte_code_point(held_b);
         n++;
      end
      is_lead = 1'b1;
      k = gjd_pkg::KIND_A1;
      case (b)
         gjd_pkg::LEAD_A1:     k = gjd_pkg::KIND_A1;
         gjd_pkg::LEAD_AA:     k = gjd_pkg::KIND_AA;
         gjd_pkg::LEAD_DF:     k = gjd_pkg::KIND_DF;
         gjd_pkg::VIRAMA_BYTE: k = gjd_pkg::KIND_E8;
         default:              is_lead = 1'b0;
      endcase
      // A lead byte is held unless it ends the stream.
      if (is_lead && !eos) begin
         lead_held = 1'b1;
         held_lead = k;
      end else begin
         cps[n] = byte_code_point(b);
         n++;
      end
      return n;
   endfunction

   // Queues the result beats of one byte; the last one closes the run.
   function automatic void push_expected(input int n, input logic [1:0][13:0] cps);
      cp_beat_type beat;
      for (int i = 0; i < n; i++) begin
         beat.cp = cps[i];
         beat.last = (i == n - 1);
         expected_cps.push_back(beat);
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [13:0] got,
                                  input logic [13:0] want);
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Presents one byte and holds it until the beat is taken.
   task automatic drive_beat(input logic [7:0] b, input logic eos);
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_end_of_stream <= eos;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   task automatic idle_req(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Gap length: mostly none or short, now and then long.
   function automatic int pick_gap(input bit idle_on);
      int r;
      if (!idle_on) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 65) begin
         return 0;
      end else if (r < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // Random byte weighted toward lead and partner bytes.
   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) begin
         case ($urandom_range(0, 3))
            0: return gjd_pkg::LEAD_A1;
            1: return gjd_pkg::LEAD_AA;
            2: return gjd_pkg::LEAD_DF;
            default: return gjd_pkg::VIRAMA_BYTE;
         endcase
      end else if (r < 55) begin
         return ($urandom_range(0, 1) == 0) ? gjd_pkg::NUKTA_BYTE : gjd_pkg::VIRAMA_BYTE;
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // Result channel stall: runs and holds of random length, with calm stretches.
   initial begin : rsp_stall_gen
      int  run_len;
      bit  calm;
      forever begin
         calm = ($urandom_range(0, 7) == 0);
         run_len = calm ? $urandom_range(100, 300) : $urandom_range(1, 12);
         rsp_stall <= 1'b0;
         repeat (run_len) @(posedge clock);
         rsp_stall <= 1'b1;
         repeat (pick_gap(1'b1) + 1) @(posedge clock);
      end
   end

   // Result checker: each accepted beat against the oldest expectation.
   always @(posedge clock) begin : rsp_check
      cp_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_cps.size() == 0) begin
            report_mismatch("result beat with nothing expected", rsp_code_point, 14'h0);
         end else begin
            want = expected_cps.pop_front();
            if (rsp_code_point !== want.cp) begin
               report_mismatch("code_point", rsp_code_point, want.cp);
            end
            if (rsp_last_in_run !== want.last) begin
               report_mismatch("last_in_run", {13'd0, rsp_last_in_run}, {13'd0, want.last});
            end
         end
      end
   end

   // Stimulus: reset, directed table, then random bytes.
   initial begin : stimulus
      logic [1:0][13:0] cps;
      logic [1:0][13:0] typed_cps;
      logic [7:0]       b;
      logic             eos;
      int               n;
      int               drain;
      bit               idle_on;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: typed rows supply their own expectation.
      for (int i = 0; i < DIR_ROWS; i++) begin
         drive_beat(dir_rows[i].in_b, dir_rows[i].eos);
         n = decode_gujarati(dir_rows[i].in_b, dir_rows[i].eos, cps);
         if (dir_rows[i].typed) begin
            typed_cps[0] = dir_rows[i].cp_a;
            typed_cps[1] = dir_rows[i].cp_b;
            push_expected(dir_rows[i].n_typed, typed_cps);
         end else begin
            push_expected(n, cps);
         end
         idle_req(pick_gap(i % 2 == 1));
      end

      // Random part; idling switches on and off in stretches.
      idle_on = 1'b1;
      for (int i = 0; i < RAND_BEATS; i++) begin
         if (i % 150 == 0) begin
            idle_on = ($urandom_range(0, 2) != 0);
         end
         // Let the result side drain completely once mid-run.
         if (i == PAUSE_AT) begin
            req_valid <= 1'b0;
            while (expected_cps.size() != 0) begin
               @(posedge clock);
            end
            @(posedge clock);
         end
         b = pick_byte();
         eos = ($urandom_range(0, 15) == 0) || (i == RAND_BEATS - 1);
         drive_beat(b, eos);
         n = decode_gujarati(b, eos, cps);
         push_expected(n, cps);
         idle_req(pick_gap(idle_on));
      end
      req_valid <= 1'b0;

      // Wait out every expected beat, then a short tail for strays.
      while (expected_cps.size() != 0) begin
         @(posedge clock);
      end
      for (drain = 0; drain < DRAIN_TAIL; drain++) begin
         @(posedge clock);
      end

      if (mismatch_count == 0 && expected_cps.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
